[design/kli_pkg.sv]
// shared types and constants of the keyframe linear interpolator
package kli_pkg;

    // field widths
    localparam int TIME_W  = 24;
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 5;
    localparam int RATIO_W = 17;

    typedef logic [1:0]         cmd_t;
    typedef logic [1:0]         status_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    // command codes
    localparam cmd_t CMD_EVAL  = 2'd0;
    localparam cmd_t CMD_WRITE = 2'd1;
    localparam cmd_t CMD_SET   = 2'd2;
    localparam cmd_t CMD_READ  = 2'd3;

    // status codes
    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_UNSUPPORTED = 2'd1;
    localparam status_t ST_RANGE       = 2'd2;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // ratio of one in Q1.16 and steps of the ratio division
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
    localparam logic [4:0]         DIV_STEPS = 5'd16;

endpackage

[design/kli_ram.sv]
// generic single-port ram with registered read
module kli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[design/keyframe_linear_interpolator.sv]
// top level of the keyframe linear interpolator
//
// channel  direction  payload (lowest bit first)
// s_*      in         tdata: query_time, key_index, key_time, key_value; tuser: cmd
// m_*      out        tdata: result_value, result_time, curve_length; tuser: status
// cfg_*    in         cfg_index selects interp_mode (0) or key_count (1), cfg_data
//
// one command at a time; a new command is taken only in idle
// evaluate does one ram read per key of the segment search and runs the
// bit-serial ratio divider for 16 quotient bits
// reset clears control and configuration only; the key tables are not cleared
// a result that is not taken holds the next result before the block returns to idle
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // query_time, key_index, key_time, key_value
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_value, result_time, curve_length
    output logic [1:0]   m_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [4:0]   cfg_data
);
    import kli_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam logic [8:0] KEYS9 = 9'(MAX_KEYS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_ONE  = 4'd3;
    localparam logic [3:0] S_EV0  = 4'd4;
    localparam logic [3:0] S_SRCH = 4'd5;
    localparam logic [3:0] S_V0   = 4'd6;
    localparam logic [3:0] S_V1   = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_ADD  = 4'd10;
    localparam logic [3:0] S_LEN0 = 4'd11;
    localparam logic [3:0] S_LEN1 = 4'd12;
    localparam logic [3:0] S_LEN2 = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    function automatic logic [AW-1:0] to_addr(input logic [8:0] x);
        return x[AW-1:0];
    endfunction

    logic [3:0]   state_reg, state_next;
    cmd_t         cmd_reg, cmd_next;
    time_t        qt_reg, qt_next;
    logic [7:0]   idx_reg, idx_next;
    time_t        kt_reg, kt_next;
    value_t       kv_reg, kv_next;
    logic [4:0]   n_reg, n_next;
    logic         mode_reg;
    logic [4:0]   count_reg;
    logic [4:0]   seg_reg, seg_next;
    time_t        tcur_reg, tcur_next;
    time_t        tnext_reg, tnext_next;
    value_t       v0_reg, v0_next;
    value_t       v1_reg, v1_next;
    logic [24:0]  rem_reg, rem_next;
    time_t        dvs_reg, dvs_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic signed [34:0] prod_reg, prod_next;
    value_t       rv_reg, rv_next;
    time_t        rt_reg, rt_next;
    status_t      st_reg, st_next;
    time_t        tfirst_reg, tfirst_next;
    time_t        len_reg, len_next;
    logic         mval_reg, mval_next;
    logic [63:0]  mdata_reg, mdata_next;
    status_t      muser_reg, muser_next;

    logic         ram_we_t, ram_we_v;
    logic [AW-1:0] ram_addr;
    time_t        ram_tdata;
    logic [15:0]  ram_vdata;
    value_t       rd_v;
    logic [4:0]   n_eff;
    logic [24:0]  rem_sh;
    logic signed [16:0] vdiff;
    logic signed [34:0] acc;

    // key tables
    kli_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_times (
        .clk   (clk),
        .we    (ram_we_t),
        .addr  (ram_addr),
        .wdata (kt_reg),
        .rdata (ram_tdata)
    );

    kli_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_KEYS)) u_values (
        .clk   (clk),
        .we    (ram_we_v),
        .addr  (ram_addr),
        .wdata (kv_reg),
        .rdata (ram_vdata)
    );

    assign rd_v      = $signed(ram_vdata);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    // effective key count
    assign n_eff = (9'(count_reg) > KEYS9) ? KEYS9[4:0] : count_reg;

    // datapath helpers
    assign rem_sh = {rem_reg[23:0], 1'b0};
    assign vdiff  = $signed({v1_reg[15], v1_reg}) - $signed({v0_reg[15], v0_reg});
    assign acc    = $signed({{3{v0_reg[15]}}, v0_reg, 16'h0000}) + prod_reg
                    + 35'sd32768;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            else
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        qt_reg     <= qt_next;
        idx_reg    <= idx_next;
        kt_reg     <= kt_next;
        kv_reg     <= kv_next;
        n_reg      <= n_next;
        seg_reg    <= seg_next;
        tcur_reg   <= tcur_next;
        tnext_reg  <= tnext_next;
        v0_reg     <= v0_next;
        v1_reg     <= v1_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        ratio_reg  <= ratio_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        rv_reg     <= rv_next;
        rt_reg     <= rt_next;
        st_reg     <= st_next;
        tfirst_reg <= tfirst_next;
        len_reg    <= len_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    // command sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        qt_next     = qt_reg;
        idx_next    = idx_reg;
        kt_next     = kt_reg;
        kv_next     = kv_reg;
        n_next      = n_reg;
        seg_next    = seg_reg;
        tcur_next   = tcur_reg;
        tnext_next  = tnext_reg;
        v0_next     = v0_reg;
        v1_next     = v1_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        ratio_next  = ratio_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        rv_next     = rv_reg;
        rt_next     = rt_reg;
        st_next     = st_reg;
        tfirst_next = tfirst_reg;
        len_next    = len_reg;
        mval_next   = mval_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        ram_we_t    = 1'b0;
        ram_we_v    = 1'b0;
        ram_addr    = '0;

        // output slot drains on a transfer
        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    qt_next    = s_tdata[23:0];
                    idx_next   = s_tdata[31:24];
                    kt_next    = s_tdata[55:32];
                    kv_next    = $signed(s_tdata[71:56]);
                    n_next     = n_eff;
                    rv_next    = '0;
                    rt_next    = '0;
                    st_next    = ST_OK;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_LEN0;
                unique case (cmd_reg)
                    CMD_WRITE:
                    begin
                        if ({1'b0, idx_reg} < KEYS9)
                        begin
                            ram_we_t = 1'b1;
                            ram_we_v = 1'b1;
                            ram_addr = to_addr({1'b0, idx_reg});
                        end
                        else
                        begin
                            st_next = ST_RANGE;
                        end
                    end
                    CMD_SET:
                    begin
                        if (idx_reg < {3'b000, n_reg})
                        begin
                            ram_we_v = 1'b1;
                            ram_addr = to_addr({1'b0, idx_reg});
                        end
                        else
                        begin
                            st_next = ST_RANGE;
                        end
                    end
                    CMD_READ:
                    begin
                        if (idx_reg < {3'b000, n_reg})
                        begin
                            ram_addr   = to_addr({1'b0, idx_reg});
                            state_next = S_RD;
                        end
                        else
                        begin
                            st_next = ST_RANGE;
                        end
                    end
                    CMD_EVAL:
                    begin
                        // empty table, single key, unsupported mode, general case
                        priority if (n_reg == 5'd0)
                        begin
                            state_next = S_LEN0;
                        end
                        else if (n_reg == 5'd1)
                        begin
                            ram_addr   = to_addr(9'd0);
                            state_next = S_ONE;
                        end
                        else if (mode_reg)
                        begin
                            st_next = ST_UNSUPPORTED;
                        end
                        else
                        begin
                            ram_addr   = to_addr(9'd0);
                            state_next = S_EV0;
                        end
                    end
                    default:
                    begin
                        state_next = S_LEN0;
                    end
                endcase
            end
            S_RD:
            begin
                rv_next    = rd_v;
                rt_next    = ram_tdata;
                state_next = S_LEN0;
            end
            S_ONE:
            begin
                rv_next    = rd_v;
                state_next = S_LEN0;
            end
            S_EV0:
            begin
                // query before the first key takes the first value
                if (qt_reg < ram_tdata)
                begin
                    rv_next    = rd_v;
                    state_next = S_LEN0;
                end
                else
                begin
                    tcur_next  = ram_tdata;
                    seg_next   = '0;
                    ram_addr   = to_addr(9'd1);
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                // first matching segment, else the last one
                if ((qt_reg >= tcur_reg && qt_reg < ram_tdata)
                    || seg_reg == n_reg - 5'd2)
                begin
                    tnext_next = ram_tdata;
                    ram_addr   = to_addr(9'(seg_reg));
                    state_next = S_V0;
                end
                else
                begin
                    tcur_next  = ram_tdata;
                    seg_next   = seg_reg + 5'd1;
                    ram_addr   = to_addr(9'(seg_reg) + 9'd2);
                end
            end
            S_V0:
            begin
                v0_next    = rd_v;
                ram_addr   = to_addr(9'(seg_reg) + 9'd1);
                state_next = S_V1;
            end
            S_V1:
            begin
                v1_next = rd_v;
                // ratio clamps, otherwise divide
                priority if (qt_reg <= tcur_reg)
                begin
                    ratio_next = '0;
                    state_next = S_MUL;
                end
                else if (qt_reg >= tnext_reg)
                begin
                    ratio_next = RATIO_ONE;
                    state_next = S_MUL;
                end
                else
                begin
                    rem_next   = {1'b0, qt_reg - tcur_reg};
                    dvs_next   = tnext_reg - tcur_reg;
                    ratio_next = '0;
                    cnt_next   = DIV_STEPS;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, dvs_reg})
                begin
                    rem_next   = rem_sh - {1'b0, dvs_reg};
                    ratio_next = {ratio_reg[RATIO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next   = rem_sh;
                    ratio_next = {ratio_reg[RATIO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = 35'(vdiff * $signed({1'b0, ratio_reg}));
                state_next = S_ADD;
            end
            S_ADD:
            begin
                rv_next    = acc[31:16];
                state_next = S_LEN0;
            end
            S_LEN0:
            begin
                if (n_reg == 5'd0)
                begin
                    len_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    ram_addr   = to_addr(9'd0);
                    state_next = S_LEN1;
                end
            end
            S_LEN1:
            begin
                tfirst_next = ram_tdata;
                ram_addr    = to_addr(9'(n_reg) - 9'd1);
                state_next  = S_LEN2;
            end
            S_LEN2:
            begin
                len_next   = ram_tdata - tfirst_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!mval_reg || m_tready)
                begin
                    mval_next  = 1'b1;
                    mdata_next = {len_reg, rt_reg, rv_reg};
                    muser_next = st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // an accepted command starts execution next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted command did not start");

    // the divider never runs with an exhausted step count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg != 5'd0))
        else $error("divider step count exhausted");

    // a finished result waits while the output slot is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && mval_reg && !m_tready) |=> (state_reg == S_OUT))
        else $error("result overwrote an untaken output");

endmodule

[bench/testbench.sv]
// self-checking testbench of the keyframe linear interpolator
module testbench;
    import kli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS     = 16;
    localparam int IDLE_LIM  = 20000;

    typedef struct packed {
        cmd_t   cmd;
        time_t  qtime;
        logic [7:0] kidx;
        time_t  ktime;
        value_t kval;
    } command_t;

    typedef struct packed {
        value_t  value;
        time_t   rtime;
        time_t   length;
        status_t status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    keyframe_linear_interpolator #(.MAX_KEYS(NKEYS)) dut (.*);

    always #10 clk = ~clk;

    // shadow state of the key table and registers
    time_t  shadow_times [NKEYS];
    value_t shadow_values [NKEYS];
    logic   shadow_mode;
    logic [4:0] shadow_count;

    command_t pending_cmds [$];
    answer_t  expected_answers [$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int idle_cycles = 0;
    int hold_off = 0;

    function automatic value_t blend_values(value_t a, value_t b, logic [16:0] r);
        logic signed [40:0] acc;
        acc = a * $signed({1'b0, 17'h10000 - r}) + b * $signed({1'b0, r}) + 41'sd32768;
        return value_t'(acc >>> 16);
    endfunction

    function automatic answer_t predict_answer(command_t c);
        answer_t a;
        int n, seg;
        logic [16:0] r;
        time_t t0, t1;
        a = '0;
        n = (shadow_count > NKEYS) ? NKEYS : shadow_count;
        case (c.cmd)
            CMD_EVAL:
            begin
                if (n == 1)
                    a.value = shadow_values[0];
                else if (n >= 2 && shadow_mode)
                    a.status = ST_UNSUPPORTED;
                else if (n >= 2 && c.qtime < shadow_times[0])
                    a.value = shadow_values[0];
                else if (n >= 2)
                begin
                    seg = n - 2;
                    for (int i = 0; i + 1 < n; i++)
                        if (c.qtime >= shadow_times[i] && c.qtime < shadow_times[i+1])
                        begin
                            seg = i;
                            break;
                        end
                    t0 = shadow_times[seg];
                    t1 = shadow_times[seg+1];
                    if (c.qtime <= t0)
                        r = 0;
                    else if (c.qtime >= t1)
                        r = RATIO_ONE;
                    else
                        r = 17'((48'(c.qtime - t0) << 16) / 48'(t1 - t0));
                    a.value = blend_values(shadow_values[seg], shadow_values[seg+1], r);
                end
            end
            CMD_WRITE:
            begin
                if (c.kidx < NKEYS)
                begin
                    shadow_times[c.kidx] = c.ktime;
                    shadow_values[c.kidx] = c.kval;
                end
                else
                    a.status = ST_RANGE;
            end
            CMD_SET:
            begin
                if (c.kidx < n)
                    shadow_values[c.kidx] = c.kval;
                else
                    a.status = ST_RANGE;
            end
            default:
            begin
                if (c.kidx < n)
                begin
                    a.value = shadow_values[c.kidx];
                    a.rtime = shadow_times[c.kidx];
                end
                else
                    a.status = ST_RANGE;
            end
        endcase
        if (n != 0)
            a.length = shadow_times[n-1] - shadow_times[0];
        return a;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on %s at result %0d: got %0h expected %0h",
                 what, received, got, want);
    endtask

    // driver: one transfer per item, random gap after each
    int src_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_answers.push_back(predict_answer(pending_cmds.pop_front()));
                sent++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !cfg_valid)
                begin
                    command_t c;
                    c = pending_cmds[0];
                    s_tvalid <= 1'b1;
                    s_tdata <= {c.kval, c.ktime, c.kidx, c.qtime};
                    s_tuser <= c.cmd;
                    src_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares results and stalls the output side
    int dst_gap = 0;
    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tdata[39:16], m_tdata[63:40], m_tuser};
                received++;
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected result", longint'(got), 0);
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("result_value", got.value, want.value);
                    if (got.rtime !== want.rtime)
                        report_mismatch("result_time", got.rtime, want.rtime);
                    if (got.length !== want.length)
                        report_mismatch("curve_length", got.length, want.length);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
                dst_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else if (dst_gap > 0)
            begin
                dst_gap <= dst_gap - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIM)
        begin
            $display("keyframe_linear_interpolator regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [4:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE)
            shadow_mode = data[0];
        else
            shadow_count = data;
    endtask

    function automatic command_t make_cmd(cmd_t cmd, time_t qt, logic [7:0] idx,
                                          time_t kt, value_t kv);
        command_t c;
        c.cmd = cmd;
        c.qtime = qt;
        c.kidx = idx;
        c.ktime = kt;
        c.kval = kv;
        return c;
    endfunction

    function automatic value_t rand_value();
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return value_t'($urandom());
        endcase
    endfunction

    // load n ascending keys; indexes 0 to n-1 are written
    task automatic load_keys(int n, bit wide);
        time_t t;
        t = wide ? 0 : time_t'($urandom_range(0, 1000));
        for (int i = 0; i < n; i++)
        begin
            pending_cmds.push_back(make_cmd(CMD_WRITE, time_t'($urandom()), 8'(i), t,
                                            rand_value()));
            t = t + (wide ? time_t'(24'hffffff / n) : time_t'($urandom_range(1, 3000)));
        end
    endtask

    function automatic time_t rand_query();
        case ($urandom_range(0, 5))
            0: return 24'hffffff;
            1: return 0;
            2: return time_t'($urandom());
            default: return time_t'($urandom_range(0, 60000));
        endcase
    endfunction

    function automatic command_t rand_cmd(int n);
        logic [7:0] idx;
        idx = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, n + 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return make_cmd(CMD_EVAL, rand_query(), 8'($urandom()),
                                              time_t'($urandom()), rand_value());
            6: return make_cmd(CMD_SET, time_t'($urandom()), idx, time_t'($urandom()),
                               rand_value());
            7, 8: return make_cmd(CMD_READ, time_t'($urandom()), idx,
                                  time_t'($urandom()), rand_value());
            default: return make_cmd(CMD_WRITE, time_t'($urandom()),
                                     $urandom_range(0, 4) == 0 ? 8'($urandom()) :
                                     8'($urandom_range(0, 15)),
                                     time_t'($urandom()), rand_value());
        endcase
    endfunction

    initial
    begin
        int cnt;
        shadow_mode = 1'b0;
        shadow_count = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, then fill every entry
        write_register(CFG_MODE, 5'd1);
        pending_cmds.push_back(make_cmd(CMD_EVAL, 24'hffffff, 8'hff, 24'hffffff, 16'sh7fff));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 8'd0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SET, 0, 8'd0, 0, 16'sh1234));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 0, 8'd16, 24'h5, 16'sh8000));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 0, 8'hff, 24'h5, 16'sh8000));
        load_keys(NKEYS, 1'b1);
        wait_drained();

        // single key with unsupported mode still answers
        write_register(CFG_COUNT, 5'd1);
        pending_cmds.push_back(make_cmd(CMD_EVAL, 0, 0, 0, 0));
        wait_drained();
        write_register(CFG_COUNT, 5'd31);
        pending_cmds.push_back(make_cmd(CMD_EVAL, 24'h123, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 8'd15, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 8'd16, 0, 0));
        wait_drained();
        write_register(CFG_MODE, 5'd0);
        pending_cmds.push_back(make_cmd(CMD_EVAL, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_EVAL, 24'hffffff, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_EVAL, 24'h7ffff, 0, 0, 0));
        // unordered keys: a segment that runs backward
        pending_cmds.push_back(make_cmd(CMD_WRITE, 0, 8'd3, 24'h000010, 16'sh0100));
        pending_cmds.push_back(make_cmd(CMD_EVAL, 24'h000020, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_EVAL, 24'h300000, 0, 0, 0));
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_off = 400;
        for (int i = 0; i < 12; i++)
            pending_cmds.push_back(rand_cmd(NKEYS));
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: cnt = NKEYS;
                1: cnt = 2;
                2: cnt = $urandom_range(0, NKEYS);
                default: cnt = $urandom_range(17, 31);
            endcase
            write_register(CFG_MODE, 5'($urandom_range(0, 5) == 0));
            write_register(CFG_COUNT, 5'(cnt));
            if (ph % 3 == 0)
                load_keys(NKEYS, 1'b0);
            for (int i = 0; i < 48; i++)
                pending_cmds.push_back(rand_cmd(cnt > NKEYS ? NKEYS : cnt));
            wait_drained();
        end

        $display("covered %0d commands and %0d results over empty, single and full tables,",
                 sent, received);
        $display("both modes, out-of-range indexes and output stalls");
        if (errors == 0)
            $display("keyframe_linear_interpolator regression: pass");
        else
            $display("keyframe_linear_interpolator regression: fail");
        $finish;
    end
endmodule
